@@ rtl/ran_pkg.sv @@
package ran_pkg;

  // Element and result field widths.
  localparam int VAL_W  = 16;
  localparam int SUM_W  = 17;
  localparam int GAIN_W = 16;

  // Configuration port.
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_EPSILON = 1'b0;
  localparam int EPS_W = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd168;

  // Square accumulator, saturating.
  localparam int SQ_W  = 33;
  localparam int ACC_W = 40;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Shared restoring divider: 49-bit dividend, 32-bit divisor, one bit a cycle.
  localparam int DIV_W     = 49;
  localparam int DEN_W     = 32;
  localparam int DCNT_W    = 6;
  localparam logic [DCNT_W-1:0] DIV_LAST = 6'd48;

  // Integer square root of a 64-bit value, two bits a cycle.
  localparam int RT_IN_W  = 64;
  localparam int RT_W     = 32;
  localparam int RT_REM_W = 34;
  localparam int RCNT_W   = 5;
  localparam logic [RCNT_W-1:0] ROOT_LAST = 5'd31;
  localparam logic [RT_W-1:0] MIN_ROOT = 32'd4096;

  // Inverse root, Q.36, at most 2^36.
  localparam int INV_W = 37;

  // Emission datapath widths.
  localparam int MAG_W  = 17;
  localparam int PLO_W  = 35;
  localparam int PHI_W  = 36;
  localparam int TSUM_W = 54;
  localparam int T_W    = 41;
  localparam int QLO_W  = 37;
  localparam int QHI_W  = 36;
  localparam int OSUM_W = 57;
  localparam int OMAG_W = 31;

  localparam logic [VAL_W-1:0] SAT_POS = 16'h7FFF;
  localparam logic [VAL_W-1:0] SAT_NEG = 16'h8000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_MEAN,
    ST_MEAN_FIN,
    ST_ROOT,
    ST_INV_LOAD,
    ST_INV,
    ST_READ,
    ST_MUL1,
    ST_ADD1,
    ST_MUL2,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/ran_if.sv @@
// Input element channel.
interface ran_in_if;
  import ran_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  hidden_value;
  logic signed [VAL_W-1:0]  residual_value;
  logic signed [GAIN_W-1:0] gain;
  logic                     is_last;

  modport source (output valid, output hidden_value, output residual_value,
                  output gain, output is_last, input ready);
  modport sink (input valid, input hidden_value, input residual_value,
                input gain, input is_last, output ready);
endinterface

// Normalized result channel.
interface ran_out_if;
  import ran_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] normed_value;
  logic signed [SUM_W-1:0] residual_sum;
  logic                    last_of_run;

  modport source (output valid, output normed_value, output residual_sum,
                  output last_of_run, input ready);
  modport sink (input valid, input normed_value, input residual_sum,
                input last_of_run, output ready);
endinterface

@@ rtl/ran_ram.sv @@
module ran_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/residual_add_rms_normalizer.sv @@
// Channel  Dir  Word fields                                   Handshake
// din      in   hidden_value, residual_value, gain, is_last   valid/ready
// dout     out  normed_value, residual_sum, last_of_run       valid/ready
// apb      in   psel, penable, pwrite, paddr, pwdata, prdata  pready tied high
//
// Loading takes one cycle per element; a vector of N elements is held in one RAM.
// After the last element: flush, 49-step mean divide, 32-step square root and
// 49-step inverse divide, all through one shared divider and root unit.
// Emission then takes each element in turn (RAM read, two multiply/round stages).
// Reset clears the control state and sets epsilon to 168; the RAM needs no clearing.
// din is not ready from the last element until the final word is loaded into the
// output register; a stalled dout holds the emission sequencer in place.
module residual_add_rms_normalizer #(
  parameter int VECTOR_LENGTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  ran_in_if.sink                          din,
  ran_out_if.source                       dout,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ran_pkg::PADDR_W-1:0]     paddr,
  input  logic [ran_pkg::PDATA_W-1:0]     pwdata,
  output logic [ran_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import ran_pkg::*;

  localparam int AW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int CW = $clog2(VECTOR_LENGTH + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(VECTOR_LENGTH);
  localparam int RAM_W = SUM_W + GAIN_W;

  state_t state, state_next;

  // Control decoded from the state.
  logic in_ready;
  logic div_step;
  logic rt_step;
  logic ram_re;
  logic out_free;
  logic out_load;
  logic emit_last;

  // Configuration.
  logic [EPS_W-1:0]     epsilon;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  // Loading and accumulation.
  logic                    in_acc;
  logic                    store;
  logic signed [SUM_W-1:0] s_w;
  logic signed [2*SUM_W-1:0] sq_prod;
  logic [SQ_W-1:0]         sq_q;
  logic                    sq_pend;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W:0]          acc_sum;
  logic [ACC_W-1:0]        acc_next;
  logic [CW-1:0]           count;
  logic [AW-1:0]           emit_idx;

  // Shared divider.
  logic [DIV_W-1:0]  div_quo;
  logic [DEN_W-1:0]  div_rem;
  logic [DEN_W-1:0]  div_den;
  logic [DCNT_W-1:0] div_cnt;
  logic [DEN_W:0]    div_sh;
  logic              div_ge;
  logic [DEN_W:0]    div_diff;
  logic [DEN_W-1:0]  mean_den;

  // Square root.
  logic [RT_IN_W-1:0]  rt_val;
  logic [RT_REM_W-1:0] rt_rem;
  logic [RT_W-1:0]     rt_root;
  logic [RCNT_W-1:0]   rt_cnt;
  logic [RT_REM_W+1:0] rt_sh;
  logic [RT_REM_W+1:0] rt_trial;
  logic                rt_ge;
  logic [RT_REM_W+1:0] rt_diff;
  logic [ACC_W:0]      m_raw;
  logic [ACC_W-1:0]    m_c;

  // Emission datapath.
  logic [RAM_W-1:0]        ram_rdata;
  logic signed [SUM_W-1:0] rd_sum;
  logic signed [GAIN_W-1:0] rd_gain;
  logic [INV_W-1:0]        inv;
  logic [MAG_W-1:0]        s_mag;
  logic [GAIN_W-1:0]       g_mag;
  logic signed [SUM_W-1:0] e_sum;
  logic                    e_neg;
  logic [GAIN_W-1:0]       e_gmag;
  logic [PLO_W-1:0]        p_lo;
  logic [PHI_W-1:0]        p_hi;
  logic [TSUM_W-1:0]       t_full;
  logic [T_W-1:0]          tmag;
  logic [QLO_W-1:0]        q_lo;
  logic [QHI_W-1:0]        q_hi;
  logic [OSUM_W-1:0]       o_full;
  logic [OMAG_W-1:0]       omag;
  logic [VAL_W-1:0]        o_sat;

  // Output register.
  logic                    out_valid;
  logic [VAL_W-1:0]        out_normed;
  logic [SUM_W-1:0]        out_sum;
  logic                    out_last;

  // APB register access; epsilon is the only register.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && (reg_idx == REG_EPSILON);
  assign prdata    = (reg_idx == REG_EPSILON) ? PDATA_W'(epsilon) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (cfg_write) begin
      epsilon <= pwdata[EPS_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_acc && din.is_last) state_next = ST_FLUSH;
      ST_FLUSH:    state_next = ST_MEAN;
      ST_MEAN:     if (div_cnt == DIV_LAST) state_next = ST_MEAN_FIN;
      ST_MEAN_FIN: state_next = ST_ROOT;
      ST_ROOT:     if (rt_cnt == ROOT_LAST) state_next = ST_INV_LOAD;
      ST_INV_LOAD: state_next = ST_INV;
      ST_INV:      if (div_cnt == DIV_LAST) state_next = ST_READ;
      ST_READ:     state_next = ST_MUL1;
      ST_MUL1:     state_next = ST_ADD1;
      ST_ADD1:     state_next = ST_MUL2;
      ST_MUL2:     state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = emit_last ? ST_IDLE : ST_READ;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    div_step = 1'b0;
    rt_step  = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_MEAN:  div_step = 1'b1;
      ST_INV:   div_step = 1'b1;
      ST_ROOT:  rt_step  = 1'b1;
      ST_READ:  ram_re   = 1'b1;
      ST_EMIT:  out_load = out_free;
      default: begin
      end
    endcase
  end

  assign din.ready = in_ready;
  assign in_acc    = din.valid && in_ready;
  assign store     = in_acc && (count < COUNT_MAX);
  assign out_free  = !out_valid || dout.ready;
  assign emit_last = ((CW'(emit_idx) + CW'(1)) == count);

  // Residual add and its square; the square is folded in on the next cycle.
  assign s_w     = SUM_W'(din.hidden_value) + SUM_W'(din.residual_value);
  assign sq_prod = s_w * s_w;
  assign acc_sum = {1'b0, acc} + (ACC_W + 1)'(sq_q);
  assign acc_next = sq_pend ? (acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0]) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_pend <= 1'b0;
      acc     <= '0;
      count   <= '0;
    end else begin
      sq_pend <= store;
      if (out_load && emit_last) begin
        acc   <= '0;
        count <= '0;
      end else begin
        acc <= acc_next;
        if (store) begin
          count <= count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      sq_q <= sq_prod[SQ_W-1:0];
    end
  end

  // Element store: sum and gain side by side.
  ran_ram #(
    .WIDTH (RAM_W),
    .DEPTH (VECTOR_LENGTH)
  ) u_buf (
    .clk   (clk),
    .we    (store),
    .waddr (count[AW-1:0]),
    .wdata ({s_w, din.gain}),
    .re    (ram_re),
    .raddr (emit_idx),
    .rdata (ram_rdata)
  );

  // Divider step: one quotient bit per cycle.
  assign div_sh   = {div_rem, div_quo[DIV_W-1]};
  assign div_diff = div_sh - {1'b0, div_den};
  assign div_ge   = (div_sh >= {1'b0, div_den});
  assign mean_den = (count == '0) ? DEN_W'(1) : DEN_W'(count);

  always_ff @(posedge clk) begin
    if (state == ST_FLUSH) begin
      // The last square lands this cycle, so take the accumulator's next value.
      div_quo <= DIV_W'(acc_next);
      div_rem <= '0;
      div_den <= mean_den;
      div_cnt <= '0;
    end else if (state == ST_INV_LOAD) begin
      div_quo <= {1'b1, {(DIV_W-1){1'b0}}};
      div_rem <= '0;
      div_den <= (rt_root == '0) ? DEN_W'(1) : rt_root;
      div_cnt <= '0;
    end else if (div_step) begin
      div_quo <= {div_quo[DIV_W-2:0], div_ge};
      div_rem <= div_ge ? div_diff[DEN_W-1:0] : div_sh[DEN_W-1:0];
      div_cnt <= div_cnt + DCNT_W'(1);
    end
  end

  // Mean square plus epsilon, clamped to the accumulator range and kept nonzero.
  assign m_raw = {1'b0, div_quo[ACC_W-1:0]} + (ACC_W + 1)'(epsilon);
  always_comb begin
    if (m_raw[ACC_W]) begin
      m_c = ACC_MAX;
    end else if (m_raw[ACC_W-1:0] == '0) begin
      m_c = ACC_W'(1);
    end else begin
      m_c = m_raw[ACC_W-1:0];
    end
  end

  // Square root step: two radicand bits per cycle.
  assign rt_sh    = {rt_rem, rt_val[RT_IN_W-1 -: 2]};
  assign rt_trial = (RT_REM_W + 2)'({rt_root, 2'b01});
  assign rt_ge    = (rt_sh >= rt_trial);
  assign rt_diff  = rt_sh - rt_trial;

  always_ff @(posedge clk) begin
    if (state == ST_MEAN_FIN) begin
      rt_val  <= {m_c, {(RT_IN_W-ACC_W){1'b0}}};
      rt_rem  <= '0;
      rt_root <= '0;
      rt_cnt  <= '0;
    end else if (rt_step) begin
      rt_val  <= {rt_val[RT_IN_W-3:0], 2'b00};
      rt_rem  <= rt_ge ? rt_diff[RT_REM_W-1:0] : rt_sh[RT_REM_W-1:0];
      rt_root <= {rt_root[RT_W-2:0], rt_ge};
      rt_cnt  <= rt_cnt + RCNT_W'(1);
    end
  end

  // Emission index walks the buffer once per vector.
  always_ff @(posedge clk) begin
    if (state == ST_INV_LOAD) begin
      emit_idx <= '0;
    end else if (out_load && !emit_last) begin
      emit_idx <= emit_idx + AW'(1);
    end
  end

  // First multiply: |sum| times the inverse root, split in two partial products.
  assign inv     = div_quo[INV_W-1:0];
  assign rd_sum  = ram_rdata[RAM_W-1 -: SUM_W];
  assign rd_gain = ram_rdata[GAIN_W-1:0];
  assign s_mag   = rd_sum[SUM_W-1] ? MAG_W'(-rd_sum) : MAG_W'(rd_sum);
  assign g_mag   = rd_gain[GAIN_W-1] ? GAIN_W'(-rd_gain) : GAIN_W'(rd_gain);

  always_ff @(posedge clk) begin
    if (state == ST_MUL1) begin
      e_sum  <= rd_sum;
      e_neg  <= rd_sum[SUM_W-1] ^ rd_gain[GAIN_W-1];
      e_gmag <= g_mag;
      p_lo   <= PLO_W'(s_mag) * PLO_W'(inv[17:0]);
      p_hi   <= PHI_W'(s_mag) * PHI_W'(inv[INV_W-1:18]);
    end
  end

  // Round the scaled sum to Q.24, half away from zero on the magnitude.
  assign t_full = {p_hi, 18'b0} + TSUM_W'(p_lo) + TSUM_W'(2048);

  always_ff @(posedge clk) begin
    if (state == ST_ADD1) begin
      tmag <= t_full[52:12];
    end
  end

  // Second multiply: scaled magnitude times |gain|.
  always_ff @(posedge clk) begin
    if (state == ST_MUL2) begin
      q_lo <= QLO_W'(tmag[20:0]) * QLO_W'(e_gmag);
      q_hi <= QHI_W'(tmag[T_W-1:21]) * QHI_W'(e_gmag);
    end
  end

  // Round to Q4.12 and clamp to the 16-bit range.
  assign o_full = {q_hi, 21'b0} + OSUM_W'(q_lo) + OSUM_W'(33554432);
  assign omag   = o_full[OSUM_W-1:26];

  always_comb begin
    if (e_neg) begin
      o_sat = (omag > OMAG_W'(32768)) ? SAT_NEG : (VAL_W'(0) - omag[VAL_W-1:0]);
    end else begin
      o_sat = (omag > OMAG_W'(32767)) ? SAT_POS : omag[VAL_W-1:0];
    end
  end

  // Output register decouples the emission sequencer from dout.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_normed <= o_sat;
      out_sum    <= e_sum;
      out_last   <= emit_last;
    end
  end

  assign dout.valid        = out_valid;
  assign dout.normed_value = out_normed;
  assign dout.residual_sum = out_sum;
  assign dout.last_of_run  = out_last;

`ifndef ASSERT_OFF
  // The fill count never runs past the buffer depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_MAX)
    else $error("element count beyond buffer depth");

  // Once a vector is closed no further element is taken.
  a_close_stall: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && din.is_last) |=> !din.ready)
    else $error("element accepted after vector close");

  // Loading the final word resets the vector state.
  a_vec_clear: assert property (@(posedge clk) disable iff (rst)
    (out_load && emit_last) |=> (count == '0 && acc == '0))
    else $error("vector state not cleared after final word");

  // The mean square is at least one, so the root is at least 2^12.
  a_root_min: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INV_LOAD) |-> (rt_root >= MIN_ROOT))
    else $error("square root below its lower bound");

  // The first multiply stage always directly follows a RAM read.
  a_read_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL1) |-> $past(ram_re))
    else $error("multiply stage without a preceding RAM read");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import ran_pkg::*;

  localparam int VEC_LEN       = 64;
  localparam int SETTLE_CYCLES = 160;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [PADDR_W-1:0] EPS_ADDR = {REG_EPSILON, 2'b00};

  // Flavors of random element content.
  typedef enum int {
    STYLE_FULL,
    STYLE_SMALL,
    STYLE_SPARSE,
    STYLE_EDGE
  } value_style_t;

  // One expected output word.
  typedef struct packed {
    logic signed [VAL_W-1:0] normed;
    logic signed [SUM_W-1:0] resid;
    logic                    closing;
  } norm_word_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ran_in_if  din_bus();
  ran_out_if dout_bus();

  residual_add_rms_normalizer #(
    .VECTOR_LENGTH(VEC_LEN)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .din    (din_bus),
    .dout   (dout_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the block's vector buffers, accumulator and epsilon.
  logic signed [SUM_W-1:0]  sum_store [VEC_LEN];
  logic signed [GAIN_W-1:0] gain_store [VEC_LEN];
  logic [ACC_W-1:0]         square_sum   = '0;
  int unsigned              stored_count = 0;
  logic [EPS_W-1:0]         eps_setting  = EPS_RESET;
  norm_word_t               pending_norms [$];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int elements_sent  = 0;
  int vectors_sent   = 0;
  int words_checked  = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  // 125 MHz clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Integer square root, two bits a step.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = v;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Right shift with rounding half away from zero.
  function automatic longint round_half_away(longint x, int unsigned sh);
    longint unsigned mag;
    mag = (x < 0) ? $unsigned(-x) : $unsigned(x);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (x < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // Buffer one accepted element; on the closing element, queue the whole
  // normalized vector.
  function automatic void predict_element(logic signed [VAL_W-1:0] hv,
                                          logic signed [VAL_W-1:0] rv,
                                          logic signed [GAIN_W-1:0] gv,
                                          logic is_end);
    longint          s;
    longint          sv;
    longint          t;
    longint          o;
    longint unsigned grown;
    longint unsigned mean;
    longint unsigned root;
    longint unsigned inv;
    int unsigned     n;
    norm_word_t      w;
    s = longint'(hv) + longint'(rv);
    // Elements beyond the buffer depth are dropped.
    if (stored_count < VEC_LEN) begin
      sum_store[stored_count]  = s[SUM_W-1:0];
      gain_store[stored_count] = gv;
      grown = square_sum;
      grown += $unsigned(s * s);
      square_sum = (grown > ACC_MAX) ? ACC_MAX : grown[ACC_W-1:0];
      stored_count++;
    end
    if (!is_end) return;

    // Mean square plus epsilon, never zero, then 1/sqrt in Q.36.
    n = (stored_count == 0) ? 1 : stored_count;
    mean = square_sum / n + eps_setting;
    if (mean == 0) mean = 1;
    if (mean > ACC_MAX) mean = ACC_MAX;
    root = int_sqrt(mean << 24);
    if (root == 0) root = 1;
    inv = (64'd1 << 48) / root;

    for (int k = 0; k < stored_count; k++) begin
      sv = longint'(sum_store[k]);
      t  = round_half_away(sv * longint'(inv), 12);
      o  = round_half_away(t * longint'(gain_store[k]), 26);
      if (o > 32767) o = 32767;
      if (o < -32768) o = -32768;
      w.normed  = o[VAL_W-1:0];
      w.resid   = sum_store[k];
      w.closing = (k == stored_count - 1);
      pending_norms.insert(pending_norms.size(), w);
    end
    stored_count = 0;
    square_sum   = '0;
  endfunction

  // Compare one accepted output word with the oldest expectation.
  task automatic check_word();
    norm_word_t want;
    if (pending_norms.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected word normed=%0d resid=%0d last=%0d", $time,
               dout_bus.normed_value, dout_bus.residual_sum, dout_bus.last_of_run);
      return;
    end
    want = pending_norms.pop_front();
    words_checked++;
    if (dout_bus.normed_value !== want.normed) begin
      mismatch_count++;
      $display("%0t: normed_value expected %0d got %0d", $time, want.normed,
               dout_bus.normed_value);
    end
    if (dout_bus.residual_sum !== want.resid) begin
      mismatch_count++;
      $display("%0t: residual_sum expected %0d got %0d", $time, want.resid,
               dout_bus.residual_sum);
    end
    if (dout_bus.last_of_run !== want.closing) begin
      mismatch_count++;
      $display("%0t: last_of_run expected %0d got %0d", $time, want.closing,
               dout_bus.last_of_run);
    end
  endtask

  // Output side: checks words and throttles ready, with an occasional long
  // hold-off counted here.
  always @(posedge clk) begin
    if (rst) begin
      dout_bus.ready <= 1'b0;
    end else begin
      if (dout_bus.valid && dout_bus.ready) check_word();
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        dout_bus.ready <= 1'b0;
      end else begin
        dout_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one element, with random gaps ahead of it, and wait for acceptance.
  task automatic send_word(input logic [VAL_W-1:0] hv, input logic [VAL_W-1:0] rv,
                           input logic [GAIN_W-1:0] gv, input logic is_end);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      din_bus.valid <= 1'b0;
      @(posedge clk);
    end
    din_bus.valid          <= 1'b1;
    din_bus.hidden_value   <= hv;
    din_bus.residual_value <= rv;
    din_bus.gain           <= gv;
    din_bus.is_last        <= is_end;
    @(posedge clk);
    while (!din_bus.ready) @(posedge clk);
    predict_element(hv, rv, gv, is_end);
    elements_sent++;
    if (is_end) vectors_sent++;
  endtask

  // Drop valid, wait for every expected word, then let the block settle.
  task automatic wait_drained();
    din_bus.valid <= 1'b0;
    while (pending_norms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_epsilon();
    logic [PDATA_W-1:0] got;
    apb_read(EPS_ADDR, got);
    if (got !== PDATA_W'(eps_setting)) begin
      mismatch_count++;
      $display("%0t: epsilon readback expected %0d got %0d", $time, eps_setting, got);
    end
  endtask

  // Only called while the block is idle.
  task automatic set_epsilon(input logic [EPS_W-1:0] value);
    apb_write(EPS_ADDR, PDATA_W'(value));
    eps_setting = value;
    check_epsilon();
  endtask

  function automatic logic [VAL_W-1:0] pick_value(value_style_t style);
    case (style)
      STYLE_SMALL: begin
        return VAL_W'($urandom_range(0, 255)) - VAL_W'(128);
      end
      STYLE_SPARSE: begin
        return ($urandom_range(0, 3) == 0) ? VAL_W'($urandom) : '0;
      end
      STYLE_EDGE: begin
        case ($urandom_range(0, 4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'hFFFF;
          3: return 16'h0001;
          default: return VAL_W'($urandom);
        endcase
      end
      default: begin
        return VAL_W'($urandom);
      end
    endcase
  endfunction

  task automatic send_random_vector(input int len);
    value_style_t style;
    logic [GAIN_W-1:0] gv;
    style = value_style_t'($urandom_range(0, 3));
    for (int i = 0; i < len; i++) begin
      gv = (style == STYLE_EDGE) ? pick_value(STYLE_EDGE) : pick_value(STYLE_FULL);
      send_word(pick_value(style), pick_value(style), gv, i == len - 1);
    end
  endtask

  // Mostly short vectors, some long ones, and a few that overrun the buffer.
  task automatic run_random_phase(input int budget);
    int first;
    int len;
    int roll;
    first = elements_sent;
    while (elements_sent - first < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) len = $urandom_range(1, 8);
      else if (roll < 90) len = $urandom_range(9, VEC_LEN - 1);
      else if (roll < 96) len = VEC_LEN;
      else len = $urandom_range(VEC_LEN + 1, VEC_LEN + 6);
      send_random_vector(len);
    end
    wait_drained();
  endtask

  task automatic test_epsilon_register();
    check_epsilon();
    set_epsilon(16'hFFFF);
    set_epsilon(16'h0000);
    set_epsilon(EPS_RESET);
  endtask

  task automatic test_field_extremes();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_word(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_word(16'h7FFF, 16'h8000, 16'h0000, 1'b0);
    send_word(16'hFFFF, 16'h0001, 16'hFFFF, 1'b0);
    send_word(16'h5555, 16'hAAAA, 16'h4000, 1'b1);
    // Single-element vector.
    send_word(16'h8000, 16'h0000, 16'h7FFF, 1'b1);
    wait_drained();
  endtask

  // With epsilon at zero, an all-zero vector and one whose floored mean is
  // zero both force the mean square up to its smallest value.
  task automatic test_zero_mean_square();
    set_epsilon(16'h0000);
    send_word(16'h0000, 16'h0000, 16'h7FFF, 1'b0);
    send_word(16'h0000, 16'h0000, 16'h8000, 1'b0);
    send_word(16'h0000, 16'h0000, 16'h1234, 1'b1);
    send_word(16'h0001, 16'h0000, 16'h8000, 1'b0);
    send_word(16'h0000, 16'h0000, 16'h7FFF, 1'b1);
    wait_drained();
  endtask

  // Two full-scale sums among zero sums push the output past Q4.12 range
  // in both directions.
  task automatic test_output_saturation();
    logic [VAL_W-1:0] hv;
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_word(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
    for (int i = 2; i < 40; i++) begin
      hv = VAL_W'($urandom);
      if (hv == 16'h8000) hv = '0;
      send_word(hv, -hv, VAL_W'($urandom), i == 39);
    end
    wait_drained();
  endtask

  // The elements past the buffer depth are dropped, but the closing mark on
  // the final one still starts emission.
  task automatic test_overlong_vector();
    set_epsilon(EPS_RESET);
    for (int i = 0; i < VEC_LEN + 2; i++) begin
      send_word(pick_value(STYLE_FULL), pick_value(STYLE_FULL), pick_value(STYLE_FULL),
                i == VEC_LEN + 1);
    end
    wait_drained();
  endtask

  // The output holds off while a full vector and another behind it are
  // offered back to back; after a full drain a short vector follows.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    send_random_vector(VEC_LEN);
    send_random_vector(8);
    wait_drained();
    send_random_vector(4);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    set_epsilon(16'hFFFF);
    send_idle_pct = 30;
    recv_idle_pct = 85;
    run_random_phase(50);
    set_epsilon(EPS_W'($urandom));
    send_idle_pct = 85;
    recv_idle_pct = 30;
    run_random_phase(50);
    set_epsilon(16'h0001);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(50);
  endtask

  initial begin
    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    din_bus.valid          <= 1'b0;
    din_bus.hidden_value   <= '0;
    din_bus.residual_value <= '0;
    din_bus.gain           <= '0;
    din_bus.is_last        <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_epsilon_register();
    test_field_extremes();
    test_zero_mean_square();
    test_output_saturation();
    test_overlong_vector();
    test_backpressure();
    test_random_traffic();
    wait_drained();

    $display("Checked %0d normalized words from %0d vectors (%0d elements) in %0d cycles.",
             words_checked, vectors_sent, elements_sent, cycle_count);
    $display("Covered epsilon 0, 1, 168, 65535 and random, zero mean square, saturation,");
    $display("overrun vectors, output hold-off and three idle mixes.");
    if (mismatch_count == 0 && pending_norms.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (pending_norms.size() != 0)
        $display("%0t: %0d expected words never arrived", $time, pending_norms.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ran_pkg.sv
rtl/ran_if.sv
rtl/ran_ram.sv
rtl/residual_add_rms_normalizer.sv
tb/sv/tb.sv
